// ===== rtl/core/ohsp_pkg.sv =====
`default_nettype none
package ohsp_pkg;

    localparam int unsigned PrefixLen = 3;

    typedef enum logic [1:0] {
        PH_ID     = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_VALUE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_VALUE     = 2'd0,
        ST_SHORT_LEN = 2'd1,
        ST_TRUNC     = 2'd2
    } status_t;

    // id type codes from the top two bits
    typedef enum logic [1:0] {
        HT_UNICODE = 2'd0,
        HT_BYTES   = 2'd1,
        HT_BYTE1   = 2'd2,
        HT_BYTE4   = 2'd3
    } hdr_type_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  current_id;
        logic [7:0]  length_high;
        logic [15:0] bytes_left;
        logic [15:0] byte_offset;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  header_id;
        logic [7:0]  value_byte;
        logic [15:0] value_offset;
        logic        header_done;
        status_t     status;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/ohsp_if.sv =====
`default_nettype none
interface ohsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, data_byte, frame_last, input ready);
    modport sink (input valid, data_byte, frame_last, output ready);
endinterface

interface ohsp_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  header_id;
    logic [7:0]  value_byte;
    logic [15:0] value_offset;
    logic        header_done;
    logic [1:0]  status;

    modport source (output valid, header_id, value_byte, value_offset, header_done, status,
                    input ready);
    modport sink (input valid, header_id, value_byte, value_offset, header_done, status,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/obex_header_stream_parser_top.sv =====
// bytes are held in the input register, their results in the result register
// throughput: one byte per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken
// reset (rst_n low, asynchronous): both stages empty, parser expects a header id,
// id, length and counters cleared to zero
`default_nettype none
module obex_header_stream_parser_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ohsp_byte_if.sink     byte_stream,
    ohsp_result_if.source result
);

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_last_reg;
    ohsp_pkg::parse_state_t state_reg;
    ohsp_pkg::parse_state_t state_next;
    logic                   out_valid_reg;
    ohsp_pkg::result_t      out_reg;
    logic                   step_valid;
    ohsp_pkg::result_t      step_result;
    logic                   out_free;
    logic                   s1_advance;

    assign out_free          = !out_valid_reg || result.ready;
    assign s1_advance        = s1_valid_reg && out_free;
    assign byte_stream.ready = !s1_valid_reg || out_free;

    ohsp_step u_step (
        .state        (state_reg),
        .data_byte    (s1_byte_reg),
        .frame_last   (s1_last_reg),
        .state_next   (state_next),
        .result_valid (step_valid),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= ohsp_pkg::PH_ID;
            state_reg.current_id  <= 8'd0;
            state_reg.length_high <= 8'd0;
            state_reg.bytes_left  <= 16'd0;
            state_reg.byte_offset <= 16'd0;
        end
        else
        begin
            if (byte_stream.ready)
            begin
                s1_valid_reg <= byte_stream.valid;
            end
            if (s1_advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= step_valid;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            s1_byte_reg <= byte_stream.data_byte;
            s1_last_reg <= byte_stream.frame_last;
        end
        if (s1_advance)
        begin
            out_reg <= step_result;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.header_id    = out_reg.header_id;
    assign result.value_byte   = out_reg.value_byte;
    assign result.value_offset = out_reg.value_offset;
    assign result.header_done  = out_reg.header_done;
    assign result.status       = out_reg.status;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("input stage lost a byte under backpressure");

    a_last_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> (state_reg.phase == ohsp_pkg::PH_ID))
        else $error("parser not at header id after frame end");

    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.header_done) |-> (out_reg.status == ohsp_pkg::ST_VALUE))
        else $error("header end marked on a flag transaction");

    a_short_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ohsp_pkg::ST_SHORT_LEN)
            |-> (out_reg.value_byte == 8'd0 && out_reg.value_offset == 16'd0))
        else $error("short length flag carries value data");

endmodule
`default_nettype wire

// ===== rtl/core/ohsp_step.sv =====
`default_nettype none
module ohsp_step (
    input  ohsp_pkg::parse_state_t state,
    input  logic [7:0]             data_byte,
    input  logic                   frame_last,
    output ohsp_pkg::parse_state_t state_next,
    output logic                   result_valid,
    output ohsp_pkg::result_t      result
);

    logic [15:0] len;
    logic        done;

    assign len  = {state.length_high, data_byte};
    assign done = (state.bytes_left <= 16'd1);

    always_comb
    begin
        state_next          = state;
        result_valid        = 1'b0;
        result.header_id    = state.current_id;
        result.value_byte   = 8'd0;
        result.value_offset = 16'd0;
        result.header_done  = 1'b0;
        result.status       = ohsp_pkg::ST_TRUNC;

        case (state.phase)
            ohsp_pkg::PH_ID:
            begin
                state_next.current_id  = data_byte;
                state_next.byte_offset = 16'd0;
                result.header_id       = data_byte;
                case (ohsp_pkg::hdr_type_t'(data_byte[7:6]))
                    ohsp_pkg::HT_BYTE1:
                    begin
                        state_next.bytes_left = 16'd1;
                        state_next.phase      = ohsp_pkg::PH_VALUE;
                    end
                    ohsp_pkg::HT_BYTE4:
                    begin
                        state_next.bytes_left = 16'd4;
                        state_next.phase      = ohsp_pkg::PH_VALUE;
                    end
                    default:
                    begin
                        state_next.phase = ohsp_pkg::PH_LEN_HI;
                    end
                endcase
                result_valid = frame_last;
            end
            ohsp_pkg::PH_LEN_HI:
            begin
                state_next.length_high = data_byte;
                state_next.phase       = ohsp_pkg::PH_LEN_LO;
                result_valid           = frame_last;
            end
            ohsp_pkg::PH_LEN_LO:
            begin
                if (len < 16'(ohsp_pkg::PrefixLen))
                begin
                    result_valid     = 1'b1;
                    result.status    = ohsp_pkg::ST_SHORT_LEN;
                    state_next.phase = ohsp_pkg::PH_ID;
                end
                else if (len == 16'(ohsp_pkg::PrefixLen))
                begin
                    state_next.phase = ohsp_pkg::PH_ID;
                end
                else
                begin
                    state_next.bytes_left  = len - 16'(ohsp_pkg::PrefixLen);
                    state_next.byte_offset = 16'd0;
                    state_next.phase       = ohsp_pkg::PH_VALUE;
                    result_valid           = frame_last;
                end
            end
            default:
            begin
                result_valid        = 1'b1;
                result.value_byte   = data_byte;
                result.value_offset = state.byte_offset;
                if (done)
                begin
                    result.header_done    = 1'b1;
                    result.status         = ohsp_pkg::ST_VALUE;
                    state_next.phase      = ohsp_pkg::PH_ID;
                    state_next.bytes_left = 16'd0;
                end
                else
                begin
                    result.status         = frame_last ? ohsp_pkg::ST_TRUNC
                                                       : ohsp_pkg::ST_VALUE;
                    state_next.bytes_left = state.bytes_left - 16'd1;
                end
                state_next.byte_offset = state.byte_offset + 16'd1;
            end
        endcase

        // end of frame always resynchronizes on a header id
        if (frame_last)
        begin
            state_next.phase = ohsp_pkg::PH_ID;
        end
    end

endmodule
`default_nettype wire

// ===== verif/obex_header_stream_parser_top_tb.sv =====
`default_nettype none
module obex_header_stream_parser_top_tb;

    typedef logic [7:0] octets_t [$];

    logic clk = 1'b0;
    logic rst_n;

    ohsp_byte_if   byte_bus ();
    ohsp_result_if result_bus ();

    obex_header_stream_parser_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_bus),
        .result      (result_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the parser state
    ohsp_pkg::phase_t trk_phase;
    logic [7:0]       trk_id;
    logic [7:0]       trk_len_hi;
    logic [15:0]      trk_left;
    logic [15:0]      trk_offset;

    ohsp_pkg::result_t value_log [$];
    int                octets_sent;
    int                error_count;
    bit                tx_stalls;
    bit                rx_stalls;
    int                hold_request;

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void add_octet(ref octets_t q, input logic [7:0] b);
        q.insert(q.size(), b);
    endfunction

    // advances the shadow parser by one byte, returns 1 when a result is due
    function automatic bit parse_octet(input logic [7:0] b, input logic last,
                                       output ohsp_pkg::result_t r);
        logic [15:0] len;
        bit          due;
        due = 1'b0;
        r = '0;
        len = {trk_len_hi, b};
        case (trk_phase)
            ohsp_pkg::PH_ID:
            begin
                trk_id = b;
                trk_offset = '0;
                case (ohsp_pkg::hdr_type_t'(b[7:6]))
                    ohsp_pkg::HT_BYTE1:
                    begin
                        trk_left = 16'd1;
                        trk_phase = ohsp_pkg::PH_VALUE;
                    end
                    ohsp_pkg::HT_BYTE4:
                    begin
                        trk_left = 16'd4;
                        trk_phase = ohsp_pkg::PH_VALUE;
                    end
                    default: trk_phase = ohsp_pkg::PH_LEN_HI;
                endcase
                if (last)
                begin
                    due = 1'b1;
                    r.status = ohsp_pkg::ST_TRUNC;
                end
            end
            ohsp_pkg::PH_LEN_HI:
            begin
                trk_len_hi = b;
                trk_phase = ohsp_pkg::PH_LEN_LO;
                if (last)
                begin
                    due = 1'b1;
                    r.status = ohsp_pkg::ST_TRUNC;
                end
            end
            ohsp_pkg::PH_LEN_LO:
            begin
                if (len < ohsp_pkg::PrefixLen)
                begin
                    due = 1'b1;
                    r.status = ohsp_pkg::ST_SHORT_LEN;
                    trk_phase = ohsp_pkg::PH_ID;
                end
                else if (len == ohsp_pkg::PrefixLen)
                    trk_phase = ohsp_pkg::PH_ID;
                else
                begin
                    trk_left = len - 16'(ohsp_pkg::PrefixLen);
                    trk_offset = '0;
                    trk_phase = ohsp_pkg::PH_VALUE;
                    if (last)
                    begin
                        due = 1'b1;
                        r.status = ohsp_pkg::ST_TRUNC;
                    end
                end
            end
            default:
            begin
                due = 1'b1;
                r.value_byte = b;
                r.value_offset = trk_offset;
                if (trk_left <= 16'd1)
                begin
                    r.header_done = 1'b1;
                    r.status = ohsp_pkg::ST_VALUE;
                    trk_phase = ohsp_pkg::PH_ID;
                    trk_left = '0;
                end
                else
                begin
                    if (last)
                        r.status = ohsp_pkg::ST_TRUNC;
                    else
                        r.status = ohsp_pkg::ST_VALUE;
                    trk_left = trk_left - 16'd1;
                end
                trk_offset = trk_offset + 16'd1;
            end
        endcase
        if (last)
            trk_phase = ohsp_pkg::PH_ID;
        r.header_id = trk_id;
        return due;
    endfunction

    task automatic send_octet(input logic [7:0] b, input logic last);
        ohsp_pkg::result_t r;
        if (tx_stalls && $urandom_range(0, 7) == 0)
        begin
            byte_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        byte_bus.valid      <= 1'b1;
        byte_bus.data_byte  <= b;
        byte_bus.frame_last <= last;
        do @(posedge clk); while (!byte_bus.ready);
        octets_sent++;
        if (parse_octet(b, last, r))
            value_log.insert(value_log.size(), r);
    endtask

    task automatic send_octets(input octets_t seq, input bit end_frame);
        foreach (seq[i])
            send_octet(seq[i], end_frame && (i == seq.size() - 1));
    endtask

    task automatic wait_drain();
        byte_bus.valid <= 1'b0;
        while (value_log.size() != 0)
            @(posedge clk);
        // id and length bytes may still be in the pipe with nothing to show
        repeat (4) @(posedge clk);
    endtask

    function automatic void append_header(ref octets_t q);
        ohsp_pkg::hdr_type_t kind;
        logic [15:0]         len;
        kind = ohsp_pkg::hdr_type_t'($urandom_range(0, 3));
        add_octet(q, {kind, 6'($urandom)});
        case (kind)
            ohsp_pkg::HT_BYTE1: add_octet(q, 8'($urandom));
            ohsp_pkg::HT_BYTE4: repeat (4) add_octet(q, 8'($urandom));
            default:
            begin
                case ($urandom_range(0, 9))
                    0: len = 16'($urandom_range(0, 3));
                    1: len = 16'($urandom_range(4, 40));
                    default: len = 16'($urandom_range(4, 12));
                endcase
                add_octet(q, len[15:8]);
                add_octet(q, len[7:0]);
                for (int i = 3; i < len; i++)
                    add_octet(q, 8'($urandom));
            end
        endcase
    endfunction

    task automatic send_random_frame();
        octets_t frame;
        int      cut;
        if ($urandom_range(0, 4) == 0)
        begin
            // raw noise, lengths come out arbitrary
            repeat ($urandom_range(1, 12)) add_octet(frame, 8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 5)) append_header(frame);
            if ($urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, frame.size());
                while (frame.size() > cut)
                    void'(frame.pop_back());
            end
        end
        send_octets(frame, 1'b1);
    endtask

    task automatic test_header_types();
        send_octets('{8'h80, 8'h00}, 1'b0);
        send_octets('{8'hC0, 8'hFF, 8'h00, 8'h7F, 8'h80}, 1'b0);
    endtask

    task automatic test_length_cases();
        send_octets('{8'h48, 8'h00, 8'h02}, 1'b0);
        // prefix-only header on the final byte
        send_octets('{8'h42, 8'h00, 8'h03}, 1'b1);
    endtask

    task automatic test_frame_truncation();
        send_octets('{8'hFF}, 1'b1);
        send_octets('{8'h01, 8'h00}, 1'b1);
        send_octets('{8'h00, 8'h00, 8'h04}, 1'b1);
        send_octets('{8'h01, 8'h00, 8'h01}, 1'b1);
        send_octets('{8'h01, 8'hFF, 8'hFF, 8'hAA, 8'h55}, 1'b1);
    endtask

    task automatic test_input_stall();
        octets_t frame;
        tx_stalls = 1'b0;
        for (int i = 0; i < 20; i++)
        begin
            add_octet(frame, 8'h80 | 8'(i));
            add_octet(frame, 8'($urandom));
        end
        hold_request = 60;
        send_octets(frame, 1'b1);
    endtask

    task automatic test_drain_pause();
        tx_stalls = 1'b1;
        send_random_frame();
        wait_drain();
        send_random_frame();
    endtask

    task automatic test_random_frames();
        tx_stalls = 1'b1;
        rx_stalls = 1'b1;
        while (octets_sent < 700)
            send_random_frame();
    endtask

    task automatic test_full_rate();
        tx_stalls = 1'b0;
        rx_stalls = 1'b0;
        while (octets_sent < 850)
            send_random_frame();
    endtask

    initial
    begin : result_receiver
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                result_bus.ready <= 1'b0;
            end
            else if (rx_stalls && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 9);
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        ohsp_pkg::result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (value_log.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected transaction: id %h byte %h off %h done %b st %h",
                             result_bus.header_id, result_bus.value_byte,
                             result_bus.value_offset, result_bus.header_done,
                             result_bus.status);
            end
            else
            begin
                want = value_log.pop_front();
                if (result_bus.header_id !== want.header_id
                    || result_bus.value_byte !== want.value_byte
                    || result_bus.value_offset !== want.value_offset
                    || result_bus.header_done !== want.header_done
                    || result_bus.status !== want.status)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: exp id %h byte %h off %h done %b st %h",
                                 want.header_id, want.value_byte, want.value_offset,
                                 want.header_done, want.status,
                                 ", got id %h byte %h off %h done %b st %h",
                                 result_bus.header_id, result_bus.value_byte,
                                 result_bus.value_offset, result_bus.header_done,
                                 result_bus.status);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        byte_bus.valid = 1'b0;
        byte_bus.data_byte = '0;
        byte_bus.frame_last = 1'b0;
        trk_phase = ohsp_pkg::PH_ID;
        trk_id = '0;
        trk_len_hi = '0;
        trk_left = '0;
        trk_offset = '0;
        octets_sent = 0;
        error_count = 0;
        tx_stalls = 1'b0;
        rx_stalls = 1'b0;
        hold_request = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_types();
        test_length_cases();
        test_frame_truncation();
        wait_drain();
        test_input_stall();
        wait_drain();
        test_drain_pause();
        test_random_frames();
        test_full_rate();

        wait_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0 && value_log.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
